FILE: sv/swcd_pkg.sv
package swcd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned SCALED_W   = 17;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 3;

    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WORDS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERT = 2'd1;

    // word positions that carry a measurement
    localparam logic [IDX_W-1:0] IDX_TEMP  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_HUMID = 3'd2;

    // scale factors in hundredths
    localparam logic [14:0] TEMP_SPAN  = 15'd17500;
    localparam logic [14:0] HUMID_SPAN = 15'd10000;
    localparam logic signed [SCALED_W-1:0] TEMP_OFFSET = -17'sd4500;

    typedef enum logic [1:0] {
        CONV_NONE,
        CONV_TEMP,
        CONV_HUMID,
        CONV_ZERO
    } t_conv;

    typedef struct packed {
        logic [IDX_W-1:0]  word_index;
        logic [WORD_W-1:0] raw_word;
        logic              crc_error;
        logic              last;
    } t_word;

    typedef struct packed {
        logic  valid;
        t_word word;
    } t_push;

    // one byte through crc-8, msb first
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: sv/sensor_word_crc_deframer.sv
// Deframes a sensor response arriving one byte per word on the input channel:
// every three bytes are a big-endian 16-bit value and its crc-8 (poly 0x31,
// init 0xff), and each checked word comes out with its index, raw value and,
// when conversion is on, temperature (word 1) or humidity (word 2) in
// hundredths. A crc failure gives one error word marked last and the rest of
// the response is dropped until the next start-of-response byte. The block
// takes one byte every cycle while the queue is not full; the crc update is
// an unrolled combinational step in the front end, and the back end is a
// three-stage pipeline (multiply, reciprocal divide by 65535, output register).
// A two-entry queue sits between the two halves; the input stalls only while
// it is full. The user must write configuration through the cfg port only while
// no response is in flight; the block itself does not enforce this.
module sensor_word_crc_deframer #(
    parameter int unsigned MAX_WORDS = 6
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [swcd_pkg::BYTE_W-1:0]            i_data_byte,
    input  logic                                   i_start_of_response,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [swcd_pkg::IDX_W-1:0]             o_word_index,
    output logic [swcd_pkg::WORD_W-1:0]            o_raw_word,
    output logic signed [swcd_pkg::SCALED_W-1:0]   o_scaled_value,
    output logic                                   o_crc_error,
    output logic                                   o_last,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [swcd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [swcd_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    logic [swcd_pkg::IDX_W-1:0] r_words_per_response;
    logic                       r_convert;

    swcd_pkg::t_push            s_push;
    swcd_pkg::t_word            s_q_word;
    logic                       s_full;
    logic                       s_q_valid;
    logic                       s_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_per_response <= swcd_pkg::IDX_W'(1);
            r_convert            <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                swcd_pkg::CFG_WORDS:   r_words_per_response <= i_cfg_data[swcd_pkg::IDX_W-1:0];
                swcd_pkg::CFG_CONVERT: r_convert            <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    swcd_front #(
        .MAX_WORDS (MAX_WORDS)
    ) u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_data_byte          (i_data_byte),
        .i_start_of_response  (i_start_of_response),
        .i_words_per_response (r_words_per_response),
        .i_full               (s_full),
        .o_push               (s_push)
    );

    swcd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .o_full  (s_full),
        .o_valid (s_q_valid),
        .o_word  (s_q_word),
        .i_pop   (s_pop)
    );

    swcd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_convert      (r_convert),
        .i_word_valid   (s_q_valid),
        .i_word         (s_q_word),
        .o_pop          (s_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_word_index   (o_word_index),
        .o_raw_word     (o_raw_word),
        .o_scaled_value (o_scaled_value),
        .o_crc_error    (o_crc_error),
        .o_last         (o_last)
    );

    // an error word always closes the response
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_crc_error |-> o_last)
        else $error("error word without last");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_crc_error |-> o_scaled_value == '0)
        else $error("error word with nonzero scaled value");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_word_index) < int'(MAX_WORDS)))
        else $error("word index beyond response length");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_full |-> !s_push.valid)
        else $error("queue overflow");

endmodule

FILE: sv/swcd_front.sv
module swcd_front #(
    parameter int unsigned MAX_WORDS = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [swcd_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_start_of_response,
    input  logic [swcd_pkg::IDX_W-1:0]    i_words_per_response,
    input  logic                          i_full,
    output swcd_pkg::t_push               o_push
);

    localparam logic [swcd_pkg::IDX_W:0] MaxWords = (swcd_pkg::IDX_W + 1)'(MAX_WORDS);

    logic [1:0]                     r_pos,  n_pos;
    logic [swcd_pkg::IDX_W-1:0]     r_wcnt, n_wcnt;
    logic [swcd_pkg::BYTE_W-1:0]    r_crc,  n_crc;
    logic [swcd_pkg::BYTE_W-1:0]    r_high, n_high;
    logic [swcd_pkg::BYTE_W-1:0]    r_low,  n_low;
    logic                           r_abort, n_abort;

    logic                           s_accept;
    logic [swcd_pkg::IDX_W:0]       s_eff_words;

    assign o_ready  = !i_full;
    assign s_accept = i_valid && o_ready;

    // word count with zero taken as one and saturation at the maximum
    always_comb begin
        if (i_words_per_response == '0) begin
            s_eff_words = (swcd_pkg::IDX_W + 1)'(1);
        end else if ({1'b0, i_words_per_response} > MaxWords) begin
            s_eff_words = MaxWords;
        end else begin
            s_eff_words = {1'b0, i_words_per_response};
        end
    end

    always_comb begin
        logic [1:0]                  v_pos;
        logic [swcd_pkg::IDX_W-1:0]  v_wcnt;
        logic [swcd_pkg::BYTE_W-1:0] v_crc;
        logic                        v_abort;
        logic [swcd_pkg::BYTE_W-1:0] v_crc_next;
        logic                        v_good;
        logic                        v_fin;

        n_pos   = r_pos;
        n_wcnt  = r_wcnt;
        n_crc   = r_crc;
        n_high  = r_high;
        n_low   = r_low;
        n_abort = r_abort;
        o_push  = '0;

        v_pos   = r_pos;
        v_wcnt  = r_wcnt;
        v_crc   = r_crc;
        v_abort = r_abort;
        if (i_start_of_response) begin
            v_pos   = '0;
            v_wcnt  = '0;
            v_crc   = swcd_pkg::CRC_INIT;
            v_abort = 1'b0;
        end
        v_crc_next = swcd_pkg::crc8_byte(v_crc, i_data_byte);
        v_good     = (v_crc_next == '0);
        v_fin      = (({1'b0, v_wcnt} + (swcd_pkg::IDX_W + 1)'(1)) >= s_eff_words);

        if (s_accept) begin
            n_pos   = v_pos;
            n_wcnt  = v_wcnt;
            n_crc   = v_crc;
            n_abort = v_abort;
            if (!v_abort) begin
                n_crc = v_crc_next;
                case (v_pos)
                    2'd0: begin
                        n_high = i_data_byte;
                        n_pos  = 2'd1;
                    end
                    2'd1: begin
                        n_low = i_data_byte;
                        n_pos = 2'd2;
                    end
                    default: begin
                        // third byte closes the word
                        n_pos                  = '0;
                        n_crc                  = swcd_pkg::CRC_INIT;
                        o_push.valid           = 1'b1;
                        o_push.word.word_index = v_wcnt;
                        o_push.word.raw_word   = {r_high, r_low};
                        o_push.word.crc_error  = !v_good;
                        o_push.word.last       = !v_good || v_fin;
                        if (!v_good || v_fin) begin
                            n_abort = 1'b1;
                        end
                        if (v_good) begin
                            n_wcnt = v_wcnt + swcd_pkg::IDX_W'(1);
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_wcnt  <= '0;
            r_crc   <= swcd_pkg::CRC_INIT;
            r_high  <= '0;
            r_low   <= '0;
            r_abort <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_wcnt  <= n_wcnt;
            r_crc   <= n_crc;
            r_high  <= n_high;
            r_low   <= n_low;
            r_abort <= n_abort;
        end
    end

endmodule

FILE: sv/swcd_fifo.sv
module swcd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swcd_pkg::t_push   i_push,
    output logic              o_full,
    output logic              o_valid,
    output swcd_pkg::t_word   o_word,
    input  logic              i_pop
);

    localparam int unsigned Depth = 2;

    swcd_pkg::t_word  r_mem [Depth];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count,  n_count;

    logic             s_wr;
    logic             s_rd;

    assign o_full  = (r_count == 2'(Depth));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

    assign s_wr = i_push.valid && !o_full;
    assign s_rd = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = s_wr ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = s_rd ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (s_wr && !s_rd) begin
            n_count = r_count + 2'd1;
        end else if (s_rd && !s_wr) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (s_wr) begin
            r_mem[r_wr_ptr] <= i_push.word;
        end
    end

endmodule

FILE: sv/swcd_back.sv
module swcd_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_convert,
    input  logic                                 i_word_valid,
    input  swcd_pkg::t_word                      i_word,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [swcd_pkg::IDX_W-1:0]           o_word_index,
    output logic [swcd_pkg::WORD_W-1:0]          o_raw_word,
    output logic signed [swcd_pkg::SCALED_W-1:0] o_scaled_value,
    output logic                                 o_crc_error,
    output logic                                 o_last
);

    // stage 1: product, stage 2: quotient by 65535, then output register
    logic                          r_v1, r_v2, r_ov;
    swcd_pkg::t_word               r_w1, r_w2;
    swcd_pkg::t_conv               r_k1, r_k2;
    logic [30:0]                   r_p1;
    logic [14:0]                   r_q2;

    logic                          s_out_rdy, s_s2_rdy, s_s1_rdy;
    swcd_pkg::t_conv               s_kind;
    logic [14:0]                   s_mul_k;
    logic [30:0]                   s_prod;
    logic [31:0]                   s_sum;
    logic signed [swcd_pkg::SCALED_W-1:0] s_scaled;

    assign s_out_rdy = !r_ov || i_ready;
    assign s_s2_rdy  = !r_v2 || s_out_rdy;
    assign s_s1_rdy  = !r_v1 || s_s2_rdy;
    assign o_pop     = i_word_valid && s_s1_rdy;
    assign o_valid   = r_ov;

    always_comb begin
        if (i_word.crc_error) begin
            s_kind = swcd_pkg::CONV_ZERO;
        end else if (i_convert && i_word.word_index == swcd_pkg::IDX_TEMP) begin
            s_kind = swcd_pkg::CONV_TEMP;
        end else if (i_convert && i_word.word_index == swcd_pkg::IDX_HUMID) begin
            s_kind = swcd_pkg::CONV_HUMID;
        end else begin
            s_kind = swcd_pkg::CONV_NONE;
        end
    end

    assign s_mul_k = (s_kind == swcd_pkg::CONV_TEMP) ? swcd_pkg::TEMP_SPAN
                                                     : swcd_pkg::HUMID_SPAN;
    assign s_prod  = 31'(s_mul_k) * 31'(i_word.raw_word);

    // floor(p / 65535) = (p + (p >> 16) + 1) >> 16 while the quotient fits 16 bits
    assign s_sum = {1'b0, r_p1} + {17'b0, r_p1[30:16]} + 32'd1;

    always_comb begin
        case (r_k2)
            swcd_pkg::CONV_TEMP:  s_scaled = $signed({2'b00, r_q2}) + swcd_pkg::TEMP_OFFSET;
            swcd_pkg::CONV_HUMID: s_scaled = $signed({2'b00, r_q2});
            swcd_pkg::CONV_ZERO:  s_scaled = '0;
            default:              s_scaled = $signed({1'b0, r_w2.raw_word});
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (s_s1_rdy) begin
                r_v1 <= o_pop;
            end
            if (s_s2_rdy) begin
                r_v2 <= r_v1;
            end
            if (s_out_rdy) begin
                r_ov <= r_v2;
            end
        end
        if (s_s1_rdy) begin
            r_w1 <= i_word;
            r_k1 <= s_kind;
            r_p1 <= s_prod;
        end
        if (s_s2_rdy) begin
            r_w2 <= r_w1;
            r_k2 <= r_k1;
            r_q2 <= s_sum[30:16];
        end
        if (s_out_rdy) begin
            o_word_index   <= r_w2.word_index;
            o_raw_word     <= r_w2.raw_word;
            o_scaled_value <= s_scaled;
            o_crc_error    <= r_w2.crc_error;
            o_last         <= r_w2.last;
        end
    end

endmodule
